// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/dls_pkg.sv -----
// Types and constants of the delimited line field splitter.
`timescale 1ns / 1ps

package dls_pkg;

  // Parse phase while a line is still good
  typedef enum logic [1:0] {
    PH_START,
    PH_IN,
    PH_AFTER
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Line error codes
  localparam logic [2:0] ERR_EMPTY    = 3'd0;
  localparam logic [2:0] ERR_NO_DELIM = 3'd1;
  localparam logic [2:0] ERR_NO_FIELD = 3'd2;
  localparam logic [2:0] ERR_NO_OPEN  = 3'd3;
  localparam logic [2:0] ERR_NO_CLOSE = 3'd4;
  localparam logic [2:0] ERR_TOO_FEW  = 3'd5;
  localparam logic [2:0] ERR_TRAILING = 3'd6;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTED_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_CHAR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_CHAR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_COUNT = 3'd3;

  localparam int FCOUNT_W = 7;

  // Reset values of the configuration registers
  localparam logic [7:0]          QUOTE_CHAR_RST  = 8'd34;
  localparam logic [7:0]          DELIM_CHAR_RST  = 8'd44;
  localparam logic [FCOUNT_W-1:0] FIELD_COUNT_RST = 7'd1;

  // Output queue geometry
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [5:0] field;
    logic [2:0] code;
    logic       last;
  } result_t;

endpackage

// ----- hdl/delimited_line_field_splitter.sv -----
// Top level of the delimited line field splitter.
// The block takes one line byte or end-of-line marker per cycle while in_ready is high;
// the parse step is a single compare-and-update between the line state registers, and
// its results go into a four-entry output queue that is read one result per cycle while
// out_ready is high. in_ready stays high while that queue holds at most two results.
// With a free output side one item enters every cycle, except that an end of line that
// closes an open unquoted field yields two results; when such lines of a single byte
// follow back to back, each adds one result beyond what the output drains, and in_ready
// drops for one cycle whenever the queue reaches three. Into an empty queue, a result
// is output the cycle after its transfer. MAX_FIELDS caps the effective field count.
`timescale 1ns / 1ps

module delimited_line_field_splitter #(
  parameter int MAX_FIELDS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [7:0]                    in_byte_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_result_kind,
  output logic [7:0]                    out_data_byte,
  output logic [5:0]                    out_field_number,
  output logic [2:0]                    out_error_code,
  output logic                          out_last_of_run,
  // configuration port
  input  logic                          cfg_write_en,
  input  logic [dls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dls_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dls_pkg::*;

  localparam int FdW  = $clog2(MAX_FIELDS + 1);
  localparam int CmpW = (FdW > FCOUNT_W) ? FdW : FCOUNT_W;

  // configuration registers
  logic                quoted_mode_r;
  logic [7:0]          quote_char_r;
  logic [7:0]          delim_char_r;
  logic [FCOUNT_W-1:0] field_count_r;

  // line state
  phase_t        phase_r, phase_nxt;
  logic [FdW-1:0] fields_done_r, fields_done_nxt;
  logic          failed_r, failed_nxt;
  logic [2:0]    err_code_r, err_code_nxt;
  logic          has_bytes_r, has_bytes_nxt;

  // output queue
  result_t             oq_mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CNT_W-1:0] count_r;

  logic          in_fire, out_fire;
  logic [1:0]    n_res;
  result_t       res0, res1, verdict;
  logic [CmpW-1:0] cnt_eff, fd_ext, fd_inc_ext;
  logic          fd_ge_cnt;
  logic [5:0]    fnum;
  logic          verdict_bad;
  logic [2:0]    verdict_code;

  function automatic result_t mk_res(logic [1:0] kind, logic [7:0] data,
                                     logic [5:0] field, logic [2:0] code);
    result_t r;
    r.kind  = kind;
    r.data  = data;
    r.field = field;
    r.code  = code;
    r.last  = 1'b0;
    return r;
  endfunction

  assign in_ready  = (count_r <= OQ_CNT_W'(2));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign out_fire  = out_valid && out_ready;

  // configuration writes; out-of-range indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quoted_mode_r <= 1'b0;
      quote_char_r  <= QUOTE_CHAR_RST;
      delim_char_r  <= DELIM_CHAR_RST;
      field_count_r <= FIELD_COUNT_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_QUOTED_MODE: quoted_mode_r <= cfg_wdata[0];
        CFG_QUOTE_CHAR:  quote_char_r  <= cfg_wdata[7:0];
        CFG_DELIM_CHAR:  delim_char_r  <= cfg_wdata[7:0];
        CFG_FIELD_COUNT: field_count_r <= cfg_wdata[FCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective field count and field index views
  always_comb begin
    cnt_eff    = (CmpW'(field_count_r) > CmpW'(MAX_FIELDS)) ? CmpW'(MAX_FIELDS)
                                                             : CmpW'(field_count_r);
    fd_ext     = CmpW'(fields_done_r);
    fd_inc_ext = fd_ext + CmpW'(1);
    fd_ge_cnt  = (fd_ext >= cnt_eff);
    fnum       = fd_ext[5:0];
  end

  // parse step: next line state and up to two results
  always_comb begin
    phase_nxt       = phase_r;
    fields_done_nxt = fields_done_r;
    failed_nxt      = failed_r;
    err_code_nxt    = err_code_r;
    has_bytes_nxt   = has_bytes_r;
    res0            = '0;
    res1            = '0;
    n_res           = 2'd0;
    verdict_bad     = 1'b1;
    verdict_code    = ERR_EMPTY;
    verdict         = '0;

    if (in_fire && !in_operation) begin
      // one line byte
      has_bytes_nxt = 1'b1;
      if (!failed_r) begin
        if (quoted_mode_r) begin
          priority if (phase_r == PH_IN) begin
            n_res = 2'd1;
            if (in_byte_value == quote_char_r) begin
              res0            = mk_res(KIND_END, 8'd0, fnum, ERR_EMPTY);
              fields_done_nxt = fields_done_r + FdW'(1);
              phase_nxt       = PH_AFTER;
            end else begin
              res0 = mk_res(KIND_BYTE, in_byte_value, fnum, ERR_EMPTY);
            end
          end else if (fd_ge_cnt) begin
            failed_nxt   = 1'b1;
            err_code_nxt = ERR_TRAILING;
          end else if (phase_r == PH_AFTER) begin
            if (in_byte_value == delim_char_r) begin
              phase_nxt = PH_START;
            end else begin
              failed_nxt   = 1'b1;
              err_code_nxt = ERR_NO_DELIM;
            end
          end else begin
            if (in_byte_value == quote_char_r) begin
              phase_nxt = PH_IN;
            end else begin
              failed_nxt   = 1'b1;
              err_code_nxt = ERR_NO_OPEN;
            end
          end
        end else begin
          // unquoted: the after-quote phase acts as a field start
          if (phase_r != PH_IN && fd_ge_cnt) begin
            failed_nxt   = 1'b1;
            err_code_nxt = ERR_TRAILING;
          end else begin
            n_res = 2'd1;
            if (in_byte_value == delim_char_r) begin
              res0            = mk_res(KIND_END, 8'd0, fnum, ERR_EMPTY);
              fields_done_nxt = fields_done_r + FdW'(1);
              phase_nxt       = PH_START;
            end else begin
              res0      = mk_res(KIND_BYTE, in_byte_value, fnum, ERR_EMPTY);
              phase_nxt = PH_IN;
            end
          end
        end
      end
    end else if (in_fire) begin
      // end of line: verdict, possibly preceded by the close of an open field
      priority if (failed_r) begin
        verdict_code = err_code_r;
      end else if (!has_bytes_r) begin
        verdict_code = ERR_EMPTY;
      end else if (quoted_mode_r) begin
        priority if (phase_r == PH_IN) begin
          verdict_code = ERR_NO_CLOSE;
        end else if (phase_r == PH_START) begin
          verdict_code = ERR_NO_FIELD;
        end else if (!fd_ge_cnt) begin
          verdict_code = ERR_TOO_FEW;
        end else begin
          verdict_bad = 1'b0;
        end
      end else begin
        if (phase_r == PH_IN) begin
          res0  = mk_res(KIND_END, 8'd0, fnum, ERR_EMPTY);
          n_res = 2'd1;
          if (fd_inc_ext < cnt_eff) begin
            verdict_code = ERR_TOO_FEW;
          end else begin
            verdict_bad = 1'b0;
          end
        end else if (!fd_ge_cnt) begin
          verdict_code = ERR_TOO_FEW;
        end else begin
          verdict_bad = 1'b0;
        end
      end

      if (verdict_bad) begin
        verdict = mk_res(KIND_ERROR, 8'd0, 6'd0, verdict_code);
      end else begin
        verdict = mk_res(KIND_ACCEPT, 8'd0, 6'd0, ERR_EMPTY);
      end
      if (n_res == 2'd0) begin
        res0  = verdict;
        n_res = 2'd1;
      end else begin
        res1  = verdict;
        n_res = 2'd2;
      end

      // back to the start of a line
      phase_nxt       = PH_START;
      fields_done_nxt = '0;
      failed_nxt      = 1'b0;
      err_code_nxt    = ERR_EMPTY;
      has_bytes_nxt   = 1'b0;
    end

    // mark the last result of this item
    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end else if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_START;
      fields_done_r <= '0;
      failed_r      <= 1'b0;
      err_code_r    <= ERR_EMPTY;
      has_bytes_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      fields_done_r <= fields_done_nxt;
      failed_r      <= failed_nxt;
      err_code_r    <= err_code_nxt;
      has_bytes_r   <= has_bytes_nxt;
    end
  end

  // output queue storage
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      oq_mem[wr_ptr_r] <= res0;
    end
    if (n_res == 2'd2) begin
      oq_mem[wr_ptr_r + OQ_PTR_W'(1)] <= res1;
    end
  end

  // output queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(n_res);
      rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(out_fire);
      count_r  <= count_r + OQ_CNT_W'(n_res) - OQ_CNT_W'(out_fire);
    end
  end

  // head of the queue drives the result channel
  assign out_result_kind  = oq_mem[rd_ptr_r].kind;
  assign out_data_byte    = oq_mem[rd_ptr_r].data;
  assign out_field_number = oq_mem[rd_ptr_r].field;
  assign out_error_code   = oq_mem[rd_ptr_r].code;
  assign out_last_of_run  = oq_mem[rd_ptr_r].last;

endmodule

// ----- hdl/dls_checker.sv -----
// Port-level checker for the delimited line field splitter, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dls_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [1:0]                     out_result_kind,
  input logic [7:0]                     out_data_byte,
  input logic [5:0]                     out_field_number,
  input logic [2:0]                     out_error_code,
  input logic                           out_last_of_run
);
  import dls_pkg::*;

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a stalled result keeps its payload
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_result_kind) && $stable(out_data_byte) && $stable(out_field_number) && $stable(out_error_code) && $stable(out_last_of_run))

  // a line verdict always closes the run of its end-of-line item
  `ASSERT_IMPLIES(a_verdict_last, clk, rst_n, out_valid && (out_result_kind == KIND_ACCEPT || out_result_kind == KIND_ERROR), out_last_of_run && out_data_byte == 8'd0 && out_field_number == 6'd0)

  // only an error result carries a nonzero code
  `ASSERT_IMPLIES(a_code_only_on_error, clk, rst_n, out_valid && out_result_kind != KIND_ERROR, out_error_code == ERR_EMPTY)

  // with nothing queued the input side is open
  `ASSERT_IMPLIES(a_empty_accepts, clk, rst_n, !out_valid, in_ready)

endmodule

bind delimited_line_field_splitter dls_checker u_dls_checker (.*);

// ----- tb/delimited_line_field_splitter_tb.sv -----
// Self-checking testbench of the delimited line field splitter.
`timescale 1ns / 1ps

module delimited_line_field_splitter_tb;
  import dls_pkg::*;

  localparam int          MAX_FIELDS    = 64;
  localparam logic        OP_BYTE       = 1'b0;
  localparam logic        OP_END        = 1'b1;
  localparam logic [2:0]  CFG_IDX_LAST  = 3'd7;
  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          END_SETTLE    = 16;
  localparam int          RANDOM_ITEMS  = 1250;
  localparam int          CALM_ITEMS    = 200;

  // one input transfer of a line
  typedef struct packed {
    logic       op;
    logic [7:0] val;
  } line_item_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_operation;
  logic [7:0]            in_byte_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_result_kind;
  logic [7:0]            out_data_byte;
  logic [5:0]            out_field_number;
  logic [2:0]            out_error_code;
  logic                  out_last_of_run;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // shadow registers and line state of the predictor
  logic       set_quoted;
  logic [7:0] set_quote_ch;
  logic [7:0] set_delim_ch;
  logic [6:0] set_fcount;
  phase_t     ln_phase;
  logic [2:0] ln_err;
  int         ln_fields;
  logic       ln_failed;
  logic       ln_has_bytes;

  result_t    split_results[$];
  line_item_t line_buf[$];
  int         mismatches;
  int         items_fed;
  int         cycle_count;
  bit         calm_tail;
  bit         feed_steady;

  delimited_line_field_splitter #(
    .MAX_FIELDS(MAX_FIELDS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_byte_value   (in_byte_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_data_byte   (out_data_byte),
    .out_field_number(out_field_number),
    .out_error_code  (out_error_code),
    .out_last_of_run (out_last_of_run),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_line_state();
    ln_phase     = PH_START;
    ln_err       = ERR_EMPTY;
    ln_fields    = 0;
    ln_failed    = 1'b0;
    ln_has_bytes = 1'b0;
  endfunction

  function automatic void reset_splitter_model();
    set_quoted   = 1'b0;
    set_quote_ch = QUOTE_CHAR_RST;
    set_delim_ch = DELIM_CHAR_RST;
    set_fcount   = FIELD_COUNT_RST;
    clear_line_state();
  endfunction

  function automatic void mark_failed(logic [2:0] code);
    ln_failed = 1'b1;
    ln_err    = code;
  endfunction

  function automatic result_t make_result(logic [1:0] kind, logic [7:0] data, int fld,
                                          logic [2:0] code);
    result_t r;
    r.kind  = kind;
    r.data  = data;
    r.field = fld[5:0];
    r.code  = code;
    r.last  = 1'b0;
    return r;
  endfunction

  // Works out the results of one accepted item and queues them
  function automatic void split_line_item(logic op, logic [7:0] b);
    result_t    res[2];
    int         n;
    int         lim;
    logic [2:0] code;
    logic       bad;
    n    = 0;
    lim  = (set_fcount > MAX_FIELDS) ? MAX_FIELDS : int'(set_fcount);
    code = ERR_EMPTY;
    bad  = 1'b1;
    if (op == OP_END) begin
      if (ln_failed) begin
        code = ln_err;
      end else if (!ln_has_bytes) begin
        code = ERR_EMPTY;
      end else if (set_quoted) begin
        if (ln_phase == PH_IN) code = ERR_NO_CLOSE;
        else if (ln_phase == PH_START) code = ERR_NO_FIELD;
        else if (ln_fields < lim) code = ERR_TOO_FEW;
        else bad = 1'b0;
      end else begin
        // an open unquoted field is closed by the end of line
        if (ln_phase == PH_IN) begin
          res[n] = make_result(KIND_END, 8'h00, ln_fields, ERR_EMPTY);
          n++;
          ln_fields++;
        end
        if (ln_fields < lim) code = ERR_TOO_FEW;
        else bad = 1'b0;
      end
      if (bad) res[n] = make_result(KIND_ERROR, 8'h00, 0, code);
      else res[n] = make_result(KIND_ACCEPT, 8'h00, 0, ERR_EMPTY);
      n++;
      clear_line_state();
    end else begin
      ln_has_bytes = 1'b1;
      if (!ln_failed) begin
        if (set_quoted) begin
          if (ln_phase == PH_IN) begin
            if (b == set_quote_ch) begin
              res[n] = make_result(KIND_END, 8'h00, ln_fields, ERR_EMPTY);
              ln_fields++;
              ln_phase = PH_AFTER;
            end else begin
              res[n] = make_result(KIND_BYTE, b, ln_fields, ERR_EMPTY);
            end
            n++;
          end else if (ln_fields >= lim) begin
            mark_failed(ERR_TRAILING);
          end else if (ln_phase == PH_AFTER) begin
            if (b == set_delim_ch) ln_phase = PH_START;
            else mark_failed(ERR_NO_DELIM);
          end else begin
            if (b == set_quote_ch) ln_phase = PH_IN;
            else mark_failed(ERR_NO_OPEN);
          end
        end else if (ln_phase != PH_IN && ln_fields >= lim) begin
          mark_failed(ERR_TRAILING);
        end else begin
          // after-quote phase counts as a field start here
          ln_phase = PH_IN;
          if (b == set_delim_ch) begin
            res[n] = make_result(KIND_END, 8'h00, ln_fields, ERR_EMPTY);
            ln_fields++;
            ln_phase = PH_START;
          end else begin
            res[n] = make_result(KIND_BYTE, b, ln_fields, ERR_EMPTY);
          end
          n++;
        end
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) split_results.insert(split_results.size(), res[i]);
  endfunction

  // ------------------------------------------------- port watcher and checker

  always @(posedge clk) begin : watch_ports
    result_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else if (!rst_n) begin
      reset_splitter_model();
      split_results.delete();
    end else begin
      if (in_valid && in_ready) split_line_item(in_operation, in_byte_value);
      if (out_valid && out_ready) begin
        if (split_results.size() == 0) begin
          $error("result with none expected: result_kind %0d", out_result_kind);
          mismatches++;
        end else begin
          want = split_results.pop_front();
          if (out_result_kind !== want.kind) begin
            $error("result_kind expected %0d got %0d", want.kind, out_result_kind);
            mismatches++;
          end
          if (out_data_byte !== want.data) begin
            $error("data_byte expected %0d got %0d", want.data, out_data_byte);
            mismatches++;
          end
          if (out_field_number !== want.field) begin
            $error("field_number expected %0d got %0d", want.field, out_field_number);
            mismatches++;
          end
          if (out_error_code !== want.code) begin
            $error("error_code expected %0d got %0d", want.code, out_error_code);
            mismatches++;
          end
          if (out_last_of_run !== want.last) begin
            $error("last_of_run expected %0d got %0d", want.last, out_last_of_run);
            mismatches++;
          end
        end
      end
      // register writes take effect after this edge
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_QUOTED_MODE: set_quoted   = cfg_wdata[0];
          CFG_QUOTE_CHAR:  set_quote_ch = cfg_wdata;
          CFG_DELIM_CHAR:  set_delim_ch = cfg_wdata;
          CFG_FIELD_COUNT: set_fcount   = cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
  end

  // result side backpressure
  initial begin
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (!calm_tail && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------- drive helpers

  // One transfer on the input channel, with an optional idle burst first
  task automatic feed_symbol(input logic op, input logic [7:0] val);
    if (!calm_tail && !feed_steady && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_byte_value <= val;
    do @(posedge clk); while (!in_ready);
    items_fed++;
  endtask

  task automatic feed_line();
    foreach (line_buf[i]) feed_symbol(line_buf[i].op, line_buf[i].val);
  endtask

  // Holds the sender until every queued result has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (split_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all registers plus one unused index; unused bits get random values
  task automatic configure(input logic mode, input logic [7:0] qc, input logic [7:0] dc,
                           input logic [6:0] cnt);
    wait_drain();
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_QUOTED_MODE;
    cfg_wdata    <= {7'($urandom), mode};
    @(posedge clk);
    cfg_index <= CFG_QUOTE_CHAR;
    cfg_wdata <= qc;
    @(posedge clk);
    cfg_index <= CFG_DELIM_CHAR;
    cfg_wdata <= dc;
    @(posedge clk);
    cfg_index <= CFG_FIELD_COUNT;
    cfg_wdata <= {1'($urandom), cnt};
    @(posedge clk);
    cfg_index <= 3'($urandom_range(int'(CFG_FIELD_COUNT) + 1, int'(CFG_IDX_LAST)));
    cfg_wdata <= 8'($urandom);
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  function automatic line_item_t mk_item(logic op, logic [7:0] v);
    line_item_t it;
    it.op  = op;
    it.val = v;
    return it;
  endfunction

  function automatic logic [7:0] pick_content(logic [7:0] avoid);
    logic [7:0] v;
    do v = 8'($urandom); while (v == avoid);
    return v;
  endfunction

  // quote or delimiter candidates lean toward the byte extremes
  function automatic logic [7:0] pick_special_char();
    int roll;
    roll = $urandom_range(0, 5);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_line_byte(logic [7:0] qc, logic [7:0] dc);
    int roll;
    roll = $urandom_range(0, 3);
    if (roll == 0) return qc;
    if (roll == 1) return dc;
    return 8'($urandom);
  endfunction

  // Well-formed line for the given settings, END included
  function automatic void build_clean_line(logic quoted, logic [7:0] qc, logic [7:0] dc,
                                           int nf);
    int len;
    int f;
    bit trail;
    line_buf.delete();
    trail = ($urandom_range(0, 3) == 0);
    for (f = 0; f < nf; f++) begin
      len = (nf > 8) ? $urandom_range(0, 1) : $urandom_range(0, 4);
      // an empty last unquoted field would not be counted
      if (!quoted && f == nf - 1 && !trail && len == 0) len = 1;
      if (quoted) line_buf.insert(line_buf.size(), mk_item(OP_BYTE, qc));
      repeat (len) begin
        line_buf.insert(line_buf.size(), mk_item(OP_BYTE, pick_content(quoted ? qc : dc)));
      end
      if (quoted) line_buf.insert(line_buf.size(), mk_item(OP_BYTE, qc));
      if (f < nf - 1 || (!quoted && trail)) begin
        line_buf.insert(line_buf.size(), mk_item(OP_BYTE, dc));
      end
    end
    line_buf.insert(line_buf.size(), mk_item(OP_END, 8'($urandom)));
  endfunction

  // Breaks the line in line_buf in one of several ways, or leaves it alone
  function automatic void damage_line(logic [7:0] qc, logic [7:0] dc);
    int roll;
    int keep;
    roll = $urandom_range(0, 9);
    if (roll == 6) begin
      line_buf.insert($urandom_range(0, line_buf.size() - 1),
                      mk_item(OP_BYTE, pick_line_byte(qc, dc)));
    end else if (roll == 7 && line_buf.size() > 1) begin
      line_buf.delete($urandom_range(0, line_buf.size() - 2));
    end else if (roll == 8 && line_buf.size() > 1) begin
      keep = $urandom_range(0, line_buf.size() - 2);
      while (line_buf.size() > keep + 1) line_buf.delete(keep);
    end else if (roll == 9) begin
      line_buf.delete();
      repeat ($urandom_range(0, 6)) begin
        line_buf.insert(line_buf.size(),
                        mk_item(($urandom_range(0, 7) == 0) ? OP_END : OP_BYTE,
                                pick_line_byte(qc, dc)));
      end
      line_buf.insert(line_buf.size(), mk_item(OP_END, 8'($urandom)));
    end
  endfunction

  // ------------------------------------------------------------------- tests

  // reset settings: unquoted, comma, one field
  task automatic test_reset_settings();
    feed_symbol(OP_END, 8'h00);
    feed_symbol(OP_BYTE, 8'h00);
    feed_symbol(OP_BYTE, 8'hFF);
    feed_symbol(OP_END, 8'hFF);
  endtask

  // trailing delimiter accepted, then data past the last field
  task automatic test_unquoted_delimiters();
    configure(1'b0, QUOTE_CHAR_RST, DELIM_CHAR_RST, 7'd2);
    feed_symbol(OP_BYTE, DELIM_CHAR_RST);
    feed_symbol(OP_BYTE, DELIM_CHAR_RST);
    feed_symbol(OP_END, 8'h00);
    feed_symbol(OP_BYTE, DELIM_CHAR_RST);
    feed_symbol(OP_BYTE, DELIM_CHAR_RST);
    feed_symbol(OP_BYTE, 8'h41);
    feed_symbol(OP_END, 8'h00);
  endtask

  // zero fields, and a count above the cap that fills field 63
  task automatic test_field_count_bounds();
    configure(1'b0, QUOTE_CHAR_RST, DELIM_CHAR_RST, 7'd0);
    feed_symbol(OP_END, 8'h00);
    feed_symbol(OP_BYTE, 8'h41);
    feed_symbol(OP_END, 8'h00);
    configure(1'b0, QUOTE_CHAR_RST, DELIM_CHAR_RST, 7'd127);
    repeat (MAX_FIELDS) begin
      feed_symbol(OP_BYTE, pick_content(DELIM_CHAR_RST));
      feed_symbol(OP_BYTE, DELIM_CHAR_RST);
    end
    feed_symbol(OP_END, 8'h00);
  endtask

  // quoted fields with extreme marker bytes; delimiter and quote errors mid-line
  task automatic test_quoted_fields();
    configure(1'b1, 8'h00, 8'hFF, 7'd2);
    feed_symbol(OP_BYTE, 8'h00);
    feed_symbol(OP_BYTE, 8'h61);
    feed_symbol(OP_BYTE, 8'h00);
    feed_symbol(OP_BYTE, 8'hFF);
    feed_symbol(OP_BYTE, 8'h00);
    feed_symbol(OP_BYTE, 8'h00);
    feed_symbol(OP_END, 8'h00);
    feed_symbol(OP_BYTE, 8'h00);
    feed_symbol(OP_BYTE, 8'h00);
    feed_symbol(OP_BYTE, 8'h78);
    feed_symbol(OP_END, 8'h00);
    feed_symbol(OP_BYTE, 8'h78);
    feed_symbol(OP_END, 8'h00);
  endtask

  // mode flips in the middle of a line: inside a field and after a closing quote
  task automatic test_mode_switch();
    configure(1'b1, QUOTE_CHAR_RST, DELIM_CHAR_RST, 7'd2);
    feed_symbol(OP_BYTE, QUOTE_CHAR_RST);
    feed_symbol(OP_BYTE, 8'h61);
    configure(1'b0, QUOTE_CHAR_RST, DELIM_CHAR_RST, 7'd2);
    feed_symbol(OP_BYTE, 8'h62);
    feed_symbol(OP_END, 8'h00);
    configure(1'b1, QUOTE_CHAR_RST, DELIM_CHAR_RST, 7'd2);
    feed_symbol(OP_BYTE, QUOTE_CHAR_RST);
    feed_symbol(OP_BYTE, 8'h61);
    feed_symbol(OP_BYTE, QUOTE_CHAR_RST);
    configure(1'b0, QUOTE_CHAR_RST, DELIM_CHAR_RST, 7'd2);
    feed_symbol(OP_BYTE, 8'h63);
    feed_symbol(OP_END, 8'h00);
  endtask

  // random settings per phase, mostly well-formed lines with random content;
  // the closing stretch keeps its settings and adds no idle gaps on the input
  task automatic test_random_lines();
    logic       mode;
    logic [7:0] qc;
    logic [7:0] dc;
    logic [6:0] cnt;
    int         nf;
    int         lines;
    int         roll;
    int         start_items;
    start_items = items_fed;
    nf          = 1;
    while (items_fed - start_items < RANDOM_ITEMS) begin
      if (!calm_tail) begin
        mode = 1'($urandom);
        qc   = pick_special_char();
        dc   = pick_special_char();
        if (dc == qc && $urandom_range(0, 3) != 0) dc = ~qc;
        roll = $urandom_range(0, 19);
        if (roll == 0) cnt = 7'd0;
        else if (roll == 1) cnt = 7'($urandom_range(MAX_FIELDS, 127));
        else cnt = 7'($urandom_range(1, 5));
        feed_steady = ($urandom_range(0, 3) == 0);
        configure(mode, qc, dc, cnt);
        nf = (cnt > MAX_FIELDS) ? MAX_FIELDS : int'(cnt);
      end
      lines = (nf > 8) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      repeat (lines) begin
        if (items_fed - start_items > RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
        build_clean_line(mode, qc, dc, nf);
        damage_line(qc, dc);
        feed_line();
      end
    end
  endtask

  // ------------------------------------------------------------------- main

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_BYTE;
    in_byte_value = 8'h00;
    cfg_write_en  = 1'b0;
    cfg_index     = CFG_QUOTED_MODE;
    cfg_wdata     = '0;
    mismatches    = 0;
    items_fed     = 0;
    cycle_count   = 0;
    calm_tail     = 1'b0;
    feed_steady   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_unquoted_delimiters();
    test_field_count_bounds();
    test_quoted_fields();
    test_mode_switch();
    test_random_lines();

    wait_drain();
    repeat (END_SETTLE) @(posedge clk);
    if (split_results.size() != 0) begin
      $error("%0d results never arrived", split_results.size());
      mismatches += split_results.size();
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
